[hw/rtl/mbag_pkg.sv]
`timescale 1ns / 1ps

package mbag_pkg;

  localparam int unsigned CAPACITY  = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ENTRIES_W = 5;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_e;

  typedef struct packed {
    req_e               req_type;
    logic signed [31:0] item_value;
  } req_t;

  typedef struct packed {
    logic       done_ok;
    logic [4:0] entries_held;
  } rsp_t;

  // Broadcast to every cell, already qualified by the input transaction
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

  // Passed from cell i to cell i+1
  typedef struct packed {
    logic valid;
    logic found;
  } link_t;

  // Passed from cell i+1 down to cell i for the shift on remove
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] data;
  } shift_t;

endpackage

[hw/rtl/mbag_cell.sv]
`timescale 1ns / 1ps

module mbag_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mbag_pkg::cell_cmd_t cmd_i,
  input  mbag_pkg::link_t    prev_i,
  output mbag_pkg::link_t    next_o,
  input  mbag_pkg::shift_t   up_i,
  output mbag_pkg::shift_t   down_o
);

  logic                        valid_q, valid_d;
  logic [mbag_pkg::DATA_W-1:0] data_q, data_d;
  logic                        match;
  logic                        found;
  logic                        shift;
  logic                        load;

  assign match = valid_q && (data_q == cmd_i.value);
  assign found = prev_i.found | match;
  // every cell at or above the first match takes its upper neighbor's entry
  assign shift = cmd_i.rem && found;
  // the lowest empty cell takes the new value
  assign load  = cmd_i.ins && !valid_q && prev_i.valid;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (shift) begin
      valid_d = up_i.valid;
      data_d  = up_i.data;
    end else if (load) begin
      valid_d = 1'b1;
      data_d  = cmd_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign next_o.valid = valid_q;
  assign next_o.found = found;
  assign down_o.valid = valid_q;
  assign down_o.data  = data_q;

endmodule

[hw/rtl/multiset_bag_store.sv]
`timescale 1ns / 1ps

// Bag of up to 16 signed 32-bit values held in a row of cells, filled from
// the bottom. Insert appends at the lowest empty cell and is refused when all
// cells are held; remove drops the lowest-positioned equal entry and every
// cell above it moves down one place. Each request yields one response with
// the success flag and the number of entries held afterwards. All cells
// compare in parallel and the first-match flag ripples up the row. The
// response sits in an output register and shows up the cycle after the
// request; the next request is taken in the same cycle that the response is
// taken, so one request per cycle is sustained while the receiver keeps up,
// and a stalled response holds off the input.
module multiset_bag_store (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mbag_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mbag_pkg::rsp_t out_data_o
);

  localparam int unsigned N = mbag_pkg::CAPACITY;

  mbag_pkg::cell_cmd_t          cmd;
  mbag_pkg::link_t              link  [N+1];
  mbag_pkg::shift_t             shv   [N+1];
  logic [N-1:0]                 held;
  logic                         accept;
  logic                         ok;
  logic [mbag_pkg::ENTRIES_W-1:0] fill_q, fill_d;
  logic                         out_valid_q, out_valid_d;
  mbag_pkg::rsp_t               rsp_q, rsp_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign cmd.ins   = accept && (in_data_i.req_type == mbag_pkg::REQ_INSERT);
  assign cmd.rem   = accept && (in_data_i.req_type == mbag_pkg::REQ_REMOVE);
  assign cmd.value = in_data_i.item_value;

  assign link[0].valid = 1'b1;
  assign link[0].found = 1'b0;
  assign shv[N].valid  = 1'b0;
  assign shv[N].data   = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    mbag_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .prev_i (link[i]),
      .next_o (link[i+1]),
      .up_i   (shv[i+1]),
      .down_o (shv[i])
    );
    assign held[i] = link[i+1].valid;
  end

  always_comb begin
    if (in_data_i.req_type == mbag_pkg::REQ_INSERT) begin
      ok = !held[N-1];
    end else begin
      ok = link[N].found;
    end

    fill_d = fill_q;
    if (accept && ok) begin
      if (in_data_i.req_type == mbag_pkg::REQ_INSERT) begin
        fill_d = fill_q + 1'b1;
      end else begin
        fill_d = fill_q - 1'b1;
      end
    end

    out_valid_d = out_valid_q;
    rsp_d       = rsp_q;
    if (accept) begin
      out_valid_d        = 1'b1;
      rsp_d.done_ok      = ok;
      rsp_d.entries_held = fill_d;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;

  // the count tracks the number of held cells
  a_fill_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q == mbag_pkg::ENTRIES_W'($countones(held)))
    else $error("fill count differs from held cells");

  // held cells always form a contiguous run from the bottom
  a_held_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((held + 1'b1) & held) == '0)
    else $error("gap in held cells");

  // an insert into a full bag is refused
  a_full_insert_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.ins && held[N-1]) |=> (out_valid_q && !rsp_q.done_ok))
    else $error("insert into full bag accepted");

  // a pending response reports the current count
  a_rsp_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (rsp_q.entries_held == fill_q))
    else $error("response count out of date");

endmodule

[test/bag_checker.sv]
`timescale 1ns / 1ps

module bag_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  mbag_pkg::req_t in_data_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  mbag_pkg::rsp_t out_data_i,
  output int             errors_o,
  output int             pending_o
);

  logic [mbag_pkg::DATA_W-1:0] bag_slots [mbag_pkg::CAPACITY];
  int                          bag_fill;
  mbag_pkg::rsp_t              rsp_q [$];

  task automatic report_mismatch(input string msg);
    $display("bag_checker: %0t: %s", $realtime, msg);
    errors_o++;
  endtask

  // Insert appends at the top; remove drops the lowest equal entry and
  // closes the gap by moving everything above it down one place.
  function automatic mbag_pkg::rsp_t bag_apply(input mbag_pkg::req_t r);
    mbag_pkg::rsp_t res;
    int             hit;
    int             k;
    res.done_ok = 1'b0;
    if (r.req_type == mbag_pkg::REQ_INSERT) begin
      if (bag_fill < mbag_pkg::CAPACITY) begin
        bag_slots[bag_fill] = r.item_value;
        bag_fill++;
        res.done_ok = 1'b1;
      end
    end else begin
      hit = -1;
      for (k = 0; k < bag_fill; k++) begin
        if (hit < 0 && bag_slots[k] == r.item_value) hit = k;
      end
      if (hit >= 0) begin
        for (k = hit; k + 1 < bag_fill; k++) bag_slots[k] = bag_slots[k + 1];
        bag_fill--;
        res.done_ok = 1'b1;
      end
    end
    res.entries_held = mbag_pkg::ENTRIES_W'(bag_fill);
    return res;
  endfunction

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    mbag_pkg::rsp_t want;
    if (!rst_ni) begin
      bag_fill = 0;
      rsp_q.delete();
      pending_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) rsp_q.push_back(bag_apply(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (rsp_q.size() == 0) begin
          report_mismatch($sformatf("response with nothing outstanding (ok=%0b held=%0d)",
                                    out_data_i.done_ok, out_data_i.entries_held));
        end else begin
          want = rsp_q.pop_front();
          if (out_data_i.done_ok !== want.done_ok)
            report_mismatch($sformatf("done_ok expected %0b got %0b",
                                      want.done_ok, out_data_i.done_ok));
          if (out_data_i.entries_held !== want.entries_held)
            report_mismatch($sformatf("entries_held expected %0d got %0d",
                                      want.entries_held, out_data_i.entries_held));
        end
      end
      pending_o = rsp_q.size();
    end
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_LEN   = 400;

  logic           clk;
  logic           rst_ni;
  logic           in_valid;
  logic           in_ready;
  mbag_pkg::req_t in_data;
  logic           out_valid;
  logic           out_ready;
  mbag_pkg::rsp_t out_data;

  int bag_errors;
  int rsp_pending;

  int send_idle_pct;
  int stall_pct;
  bit hold_req;
  int hold_left;
  int quiet_cycles;

  logic [mbag_pkg::DATA_W-1:0] value_pool [8];

  int idle_modes [4][2] = '{'{0, 0}, '{84, 0}, '{0, 84}, '{14, 14}};
  int insert_bias [3]   = '{80, 50, 20};

  multiset_bag_store dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  bag_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_data_i (out_data),
    .errors_o   (bag_errors),
    .pending_o  (rsp_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic mbag_pkg::req_t mk_req(input mbag_pkg::req_e kind,
                                            input logic [mbag_pkg::DATA_W-1:0] v);
    mbag_pkg::req_t r;
    r.req_type   = kind;
    r.item_value = v;
    return r;
  endfunction

  // Mostly values from a small pool so removes hit and duplicates pile up
  function automatic mbag_pkg::req_t pick_req(input int ins_pct);
    mbag_pkg::req_e              kind;
    logic [mbag_pkg::DATA_W-1:0] v;
    int                          sel;
    kind = ($urandom_range(99) < ins_pct) ? mbag_pkg::REQ_INSERT : mbag_pkg::REQ_REMOVE;
    sel  = $urandom_range(9);
    if (sel < 6) v = value_pool[$urandom_range(7)];
    else if (sel < 8) v = $urandom();
    else begin
      case ($urandom_range(3))
        0: v = 32'h8000_0000;
        1: v = 32'h7fff_ffff;
        2: v = 32'h0000_0000;
        default: v = 32'hffff_ffff;
      endcase
    end
    return mk_req(kind, v);
  endfunction

  task automatic refill_pool();
    int i;
    for (i = 0; i < 8; i++) begin
      value_pool[i] = ($urandom_range(1) == 0) ? $urandom() : 32'($urandom_range(20));
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction
  task automatic send_req(input mbag_pkg::req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  initial begin
    int i;
    int m;
    int b;
    rst_ni        = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 1'b0;
    refill_pool();
    repeat (9) @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    // Directed: empty remove, extremes, duplicates, miss, full bag, refused insert
    send_req(mk_req(mbag_pkg::REQ_REMOVE, 32'h0000_0000));
    send_req(mk_req(mbag_pkg::REQ_INSERT, 32'h8000_0000));
    send_req(mk_req(mbag_pkg::REQ_INSERT, 32'h7fff_ffff));
    send_req(mk_req(mbag_pkg::REQ_INSERT, 32'h0000_0000));
    send_req(mk_req(mbag_pkg::REQ_INSERT, 32'hffff_ffff));
    send_req(mk_req(mbag_pkg::REQ_INSERT, 32'd7));
    send_req(mk_req(mbag_pkg::REQ_INSERT, 32'd7));
    send_req(mk_req(mbag_pkg::REQ_REMOVE, 32'd7));
    send_req(mk_req(mbag_pkg::REQ_REMOVE, 32'd42));
    send_req(mk_req(mbag_pkg::REQ_REMOVE, 32'h8000_0000));
    for (i = 0; i < 13; i++) begin
      send_req(mk_req(mbag_pkg::REQ_INSERT, 32'h0101_0101 * (i + 1)));
    end
    send_req(mk_req(mbag_pkg::REQ_REMOVE, 32'hffff_ffff));
    send_req(mk_req(mbag_pkg::REQ_REMOVE, 32'h0101_0101 * 12));

    for (m = 0; m < 4; m++) begin
      send_idle_pct = idle_modes[m][0];
      stall_pct     = idle_modes[m][1];
      for (b = 0; b < 3; b++) begin
        refill_pool();
        repeat (130) send_req(pick_req(insert_bias[b]));
      end
    end

    // Receiver holds off while requests keep coming, so the input backs up
    send_idle_pct = 0;
    stall_pct     = 0;
    refill_pool();
    hold_req = 1'b1;
    repeat (120) send_req(pick_req(50));
    in_valid <= 1'b0;

    while (rsp_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (bag_errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule

[files.f]
hw/rtl/mbag_pkg.sv
hw/rtl/mbag_cell.sv
hw/rtl/multiset_bag_store.sv
test/bag_checker.sv
test/tb_top.sv
